FILE: src/slos_pkg.sv
// Shared constants, command codes and controller/datapath structs for the
// sorted list overlap score unit. No dependencies.
`default_nettype none

package slos_pkg;

  // Store geometry
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int VAL_W  = 32;

  // Fixed-point score
  localparam int FRAC_W    = 16;
  localparam int SCORE_W   = FRAC_W + 1;
  localparam int NUM_W     = CNT_W + FRAC_W;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  // Request commands
  localparam logic [1:0] CMD_APPEND_FIRST  = 2'd0;
  localparam logic [1:0] CMD_APPEND_SECOND = 2'd1;
  localparam logic [1:0] CMD_COMPARE       = 2'd2;

  // Walk index operations
  localparam logic [2:0] O_HOLD = 3'd0;
  localparam logic [2:0] O_ZERO = 3'd1;
  localparam logic [2:0] O_LX   = 3'd2;
  localparam logic [2:0] O_LO   = 3'd3;
  localparam logic [2:0] O_INC  = 3'd4;
  localparam logic [2:0] O_DEC  = 3'd5;

  typedef struct packed {
    logic       accept;
    logic [2:0] o_op;
    logic       rd_prev;
    logic       set_lo;
    logic       set_hi;
    logic       latch_xo;
    logic       p_load;
    logic       p_inc;
    logic       match;
    logic       walk_clear;
    logic       flag_set;
    logic       div_start;
    logic       div_step;
    logic       finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic lists_empty;
    logic o_ge_lx;
    logic o_zero;
    logic o_gt_hi;
    logic p_ge_ly;
    logic x_ge_first;
    logic x_le_last;
    logic y_eq_xo;
    logic y_gt_xo;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: src/slos_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module slos_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/slos_ctrl.sv
// Controller state machine: sequences bound search, merge walk and division.
// Depends on slos_pkg.
`default_nettype none

module slos_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [1:0]            cmd,
  output logic                       in_stall,
  input  wire slos_pkg::dp_status_t  sts,
  output slos_pkg::ctrl_cmd_t        ctl
);
  import slos_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LO_CHK  = 4'd1;
  localparam logic [3:0] S_LO_CMP  = 4'd2;
  localparam logic [3:0] S_HI_CHK  = 4'd3;
  localparam logic [3:0] S_HI_CMP  = 4'd4;
  localparam logic [3:0] S_M_CHK   = 4'd5;
  localparam logic [3:0] S_M_LATCH = 4'd6;
  localparam logic [3:0] S_P_CHK   = 4'd7;
  localparam logic [3:0] S_P_CMP   = 4'd8;
  localparam logic [3:0] S_DIV     = 4'd9;
  localparam logic [3:0] S_FINISH  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = (state != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.o_op   = O_HOLD;
    unique case (state)
      S_IDLE: begin
        ctl.accept = in_valid;
        if (in_valid && cmd == CMD_COMPARE) begin
          ctl.walk_clear = 1'b1;
          ctl.o_op       = O_ZERO;
          if (sts.lists_empty) begin
            ctl.flag_set = 1'b1;
            state_next   = S_FINISH;
          end else begin
            state_next = S_LO_CHK;
          end
        end
      end
      S_LO_CHK: begin
        if (sts.o_ge_lx) begin
          ctl.flag_set = 1'b1;
          state_next   = S_FINISH;
        end else begin
          state_next = S_LO_CMP;
        end
      end
      S_LO_CMP: begin
        if (sts.x_ge_first) begin
          ctl.set_lo = 1'b1;
          ctl.o_op   = O_LX;
          state_next = S_HI_CHK;
        end else begin
          ctl.o_op   = O_INC;
          state_next = S_LO_CHK;
        end
      end
      S_HI_CHK: begin
        ctl.rd_prev = 1'b1;
        if (sts.o_zero) begin
          ctl.flag_set = 1'b1;
          state_next   = S_FINISH;
        end else begin
          state_next = S_HI_CMP;
        end
      end
      S_HI_CMP: begin
        if (sts.x_le_last) begin
          ctl.set_hi = 1'b1;
          ctl.o_op   = O_LO;
          state_next = S_M_CHK;
        end else begin
          ctl.o_op   = O_DEC;
          state_next = S_HI_CHK;
        end
      end
      S_M_CHK: begin
        if (sts.o_gt_hi) begin
          ctl.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_M_LATCH;
        end
      end
      S_M_LATCH: begin
        ctl.latch_xo = 1'b1;
        ctl.p_load   = 1'b1;
        state_next   = S_P_CHK;
      end
      S_P_CHK: begin
        if (sts.p_ge_ly) begin
          ctl.o_op   = O_INC;
          state_next = S_M_CHK;
        end else begin
          state_next = S_P_CMP;
        end
      end
      S_P_CMP: begin
        priority if (sts.y_eq_xo) begin
          ctl.match  = 1'b1;
          ctl.o_op   = O_INC;
          state_next = S_M_CHK;
        end else if (sts.y_gt_xo) begin
          ctl.o_op   = O_INC;
          state_next = S_M_CHK;
        end else begin
          ctl.p_inc  = 1'b1;
          state_next = S_P_CHK;
        end
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/slos_dp.sv
// Datapath: list stores, counts, walk indices, comparators, restoring
// divider and result register. Depends on slos_pkg and slos_ram.
`default_nettype none

module slos_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [1:0]                   cmd,
  input  wire logic signed [slos_pkg::VAL_W-1:0] value,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_wdata,
  input  wire slos_pkg::ctrl_cmd_t          ctl,
  output slos_pkg::dp_status_t              sts,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              no_overlap,
  output logic                              overflowed,
  output logic [slos_pkg::CNT_W-1:0]        match_count,
  output logic [slos_pkg::CNT_W-1:0]        shorter_length,
  output logic [slos_pkg::SCORE_W-1:0]      score
);
  import slos_pkg::*;

  logic                    report_similarity;
  logic [CNT_W-1:0]        first_count;
  logic [CNT_W-1:0]        second_count;
  logic                    overflow_seen;
  logic signed [VAL_W-1:0] y_first;
  logic signed [VAL_W-1:0] y_last;

  logic [CNT_W-1:0]        o;
  logic [CNT_W-1:0]        p;
  logic [CNT_W-1:0]        lo;
  logic [CNT_W-1:0]        hi;
  logic [CNT_W-1:0]        start;
  logic [CNT_W-1:0]        n;
  logic signed [VAL_W-1:0] xo;
  logic                    flag;

  logic [CNT_W-1:0]        rem;
  logic [NUM_W-1:0]        quo;
  logic [DIV_CNT_W-1:0]    div_cnt;

  logic                    x_we;
  logic                    y_we;
  logic [ADDR_W-1:0]       x_raddr;
  logic [VAL_W-1:0]        x_rdata;
  logic [VAL_W-1:0]        y_rdata;
  logic [CNT_W-1:0]        o_prev;
  logic [CNT_W-1:0]        shorter;
  logic [CNT_W-1:0]        m_eff;
  logic [CNT_W-1:0]        numer;
  logic [CNT_W:0]          trial;
  logic                    trial_ge;

  // Append requests
  assign x_we = ctl.accept && (cmd == CMD_APPEND_FIRST) && (first_count < FULL_COUNT);
  assign y_we = ctl.accept && (cmd == CMD_APPEND_SECOND) && (second_count < FULL_COUNT);

  assign o_prev  = o - CNT_W'(1);
  assign x_raddr = ctl.rd_prev ? o_prev[ADDR_W-1:0] : o[ADDR_W-1:0];

  slos_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_first_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (first_count[ADDR_W-1:0]),
    .wdata (value),
    .raddr (x_raddr),
    .rdata (x_rdata)
  );

  slos_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_second_ram (
    .clk   (clk),
    .we    (y_we),
    .waddr (second_count[ADDR_W-1:0]),
    .wdata (value),
    .raddr (p[ADDR_W-1:0]),
    .rdata (y_rdata)
  );

  // Shorter length, clamped count and numerator
  assign shorter = (first_count < second_count) ? first_count : second_count;
  assign m_eff   = (n > shorter) ? shorter : n;
  assign numer   = report_similarity ? m_eff : (shorter - m_eff);

  // One restoring division step
  assign trial    = {rem, quo[NUM_W-1]};
  assign trial_ge = (trial >= {1'b0, shorter});

  // Status to the controller
  always_comb begin
    sts.lists_empty = (first_count == '0) || (second_count == '0);
    sts.o_ge_lx     = (o >= first_count);
    sts.o_zero      = (o == '0);
    sts.o_gt_hi     = (o > hi);
    sts.p_ge_ly     = (p >= second_count);
    sts.x_ge_first  = ($signed(x_rdata) >= y_first);
    sts.x_le_last   = ($signed(x_rdata) <= y_last);
    sts.y_eq_xo     = ($signed(y_rdata) == xo);
    sts.y_gt_xo     = ($signed(y_rdata) > xo);
    sts.div_last    = (div_cnt == '0);
    sts.out_free    = !out_valid || !out_stall;
  end

  // Control registers: config, counts, overflow, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      report_similarity <= 1'b0;
      first_count       <= '0;
      second_count      <= '0;
      overflow_seen     <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        report_similarity <= cfg_wdata;
      end
      if (x_we) begin
        first_count <= first_count + CNT_W'(1);
      end
      if (y_we) begin
        second_count <= second_count + CNT_W'(1);
      end
      if (ctl.accept && !x_we && !y_we &&
          (cmd == CMD_APPEND_FIRST || cmd == CMD_APPEND_SECOND)) begin
        overflow_seen <= 1'b1;
      end
      if (ctl.finish) begin
        first_count   <= '0;
        second_count  <= '0;
        overflow_seen <= 1'b0;
        out_valid     <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Track bounds of the second list as it loads
  always_ff @(posedge clk) begin
    if (y_we) begin
      if (second_count == '0) begin
        y_first <= value;
      end
      y_last <= value;
    end
  end

  // Walk indices and match count
  always_ff @(posedge clk) begin
    unique case (ctl.o_op)
      O_ZERO:  o <= '0;
      O_LX:    o <= first_count;
      O_LO:    o <= lo;
      O_INC:   o <= o + CNT_W'(1);
      O_DEC:   o <= o_prev;
      default: o <= o;
    endcase
    if (ctl.set_lo) begin
      lo <= o;
    end
    if (ctl.set_hi) begin
      hi <= o_prev;
    end
    if (ctl.latch_xo) begin
      xo <= $signed(x_rdata);
    end
    if (ctl.p_load) begin
      p <= start;
    end else if (ctl.p_inc) begin
      p <= p + CNT_W'(1);
    end
    if (ctl.walk_clear) begin
      n     <= '0;
      start <= '0;
    end else if (ctl.match) begin
      n     <= n + CNT_W'(1);
      start <= p + CNT_W'(1);
    end
    if (ctl.flag_set) begin
      flag <= 1'b1;
    end else if (ctl.walk_clear) begin
      flag <= 1'b0;
    end
  end

  // Restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      quo     <= {numer, {FRAC_W{1'b0}}};
      rem     <= '0;
      div_cnt <= DIV_CNT_W'(NUM_W - 1);
    end else if (ctl.div_step) begin
      rem     <= trial_ge ? CNT_W'(trial - {1'b0, shorter}) : trial[CNT_W-1:0];
      quo     <= {quo[NUM_W-2:0], trial_ge};
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      no_overlap     <= flag;
      overflowed     <= overflow_seen;
      match_count    <= flag ? '0 : m_eff;
      shorter_length <= shorter;
      score          <= flag ? '0 : quo[SCORE_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: src/sorted_list_overlap_score_unit.sv
// Sorted list overlap score unit: appends are accepted back to back.
// A compare stalls the input while it runs the bound searches over the first
// list, the merge walk with its probes of the second list, the serial divider
// and the retire step, which waits until the result register is free
// (single-read-port stores, serial divider). Synchronous reset clears counts,
// overflow, mode and result valid.
`default_nettype none

module sorted_list_overlap_score_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         cmd,
  input  wire logic signed [slos_pkg::VAL_W-1:0]  value,
  input  wire logic                               cfg_we,
  input  wire logic                               cfg_wdata,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    no_overlap,
  output logic                                    overflowed,
  output logic [slos_pkg::CNT_W-1:0]              match_count,
  output logic [slos_pkg::CNT_W-1:0]              shorter_length,
  output logic [slos_pkg::SCORE_W-1:0]            score
);
  import slos_pkg::*;

  ctrl_cmd_t  ctl;
  dp_status_t sts;

  // Sequence the request
  slos_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Store, walk and score
  slos_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .value          (value),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .ctl            (ctl),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .no_overlap     (no_overlap),
    .overflowed     (overflowed),
    .match_count    (match_count),
    .shorter_length (shorter_length),
    .score          (score)
  );

endmodule

`default_nettype wire
